### hw/rtl/moisture_sample_qualifier_core_defines.svh
// Assertion macros shared by the moisture sample qualifier RTL.
`ifndef MOISTURE_SAMPLE_QUALIFIER_CORE_DEFINES_SVH
`define MOISTURE_SAMPLE_QUALIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define MSQ_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("%m: check failed");

`define MSQ_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

`define MSQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define MSQ_ASSERT_ALWAYS(label, clk, rstn, cond)
`define MSQ_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define MSQ_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### hw/rtl/msq_pkg.sv
`default_nettype none

package msq_pkg;

    localparam int CFG_ADDR_BITS     = 3;
    localparam int CFG_DATA_BITS     = 16;
    localparam int POLL_BITS         = 16;
    localparam int ERRATIC_BITS      = 5;
    localparam int PERCENT_BITS      = 15;
    localparam int PERCENT_FRAC_BITS = 8;
    localparam int PERCENT_SCALE     = 100;
    // Bits that the scale factor 100 adds to a product.
    localparam int PERCENT_SCALE_BITS = 7;
    localparam int CLASS_BITS        = 2;

    localparam logic [ERRATIC_BITS-1:0] ERRATIC_LIMIT = 5'd20;
    localparam logic [PERCENT_BITS-1:0] PERCENT_FULL  = 15'd25600;

    localparam logic [CFG_ADDR_BITS-1:0] REG_POLL_PERIOD     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_VALUE       = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_VALUE       = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WET_THRESHOLD   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HUMID_THRESHOLD = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_STEP        = 3'd5;

    localparam logic [CFG_DATA_BITS-1:0] RST_POLL_PERIOD     = 16'd1000;
    localparam logic [CFG_DATA_BITS-1:0] RST_MIN_VALUE       = 16'd0;
    localparam logic [CFG_DATA_BITS-1:0] RST_MAX_VALUE       = 16'd4095;
    localparam logic [CFG_DATA_BITS-1:0] RST_WET_THRESHOLD   = 16'd1500;
    localparam logic [CFG_DATA_BITS-1:0] RST_HUMID_THRESHOLD = 16'd2500;
    localparam logic [CFG_DATA_BITS-1:0] RST_MAX_STEP        = 16'd20;

    typedef enum logic [CLASS_BITS-1:0] {
        CLASS_WET   = 2'd0,
        CLASS_HUMID = 2'd1,
        CLASS_DRY   = 2'd2,
        CLASS_ERROR = 2'd3
    } msq_class_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_start;
        logic load_out;
    } msq_cmd_t;

    typedef struct packed {
        logic div_done;
    } msq_status_t;

endpackage

`default_nettype wire

### hw/rtl/msq_div.sv
`default_nettype none

module msq_div #(
    parameter int DIVIDEND_BITS = 27,
    parameter int DIVISOR_BITS  = 12
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output logic                          done,
    output logic [DIVIDEND_BITS-1:0]      quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIVIDEND_BITS - 1);

    logic                     busy_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [DIVIDEND_BITS-1:0] dvd_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  dsr_reg;

    logic [DIVISOR_BITS:0]    shifted;
    logic [DIVISOR_BITS:0]    trial;
    logic                     ge;
    logic [DIVISOR_BITS-1:0]  rem_next;

    // Restoring division, one quotient bit per cycle; quotient bits shift
    // in where the dividend bits shift out.
    always_comb begin
        shifted  = {rem_reg, dvd_reg[DIVIDEND_BITS-1]};
        trial    = shifted - {1'b0, dsr_reg};
        ge       = shifted >= {1'b0, dsr_reg};
        rem_next = ge ? trial[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIVIDEND_BITS-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = busy_reg && (cnt_reg == CNT_LAST);
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

### hw/rtl/msq_datapath.sv
`default_nettype none
`include "moisture_sample_qualifier_core_defines.svh"

module msq_datapath #(
    parameter int SAMPLE_BITS = 12,
    parameter int OUT_BITS    = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire msq_pkg::msq_cmd_t                  cmd,
    output msq_pkg::msq_status_t                    status,
    input  wire logic [SAMPLE_BITS-1:0]             s_sample,
    input  wire logic                               cfg_we,
    input  wire logic [msq_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [msq_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output logic [OUT_BITS-1:0]                     m_tdata,
    output logic                                    m_tuser
);

    import msq_pkg::*;

    localparam int NUM_BITS = SAMPLE_BITS + PERCENT_SCALE_BITS;
    localparam int DVD_BITS = NUM_BITS + PERCENT_FRAC_BITS;

    logic [POLL_BITS-1:0]    poll_reg;
    logic [SAMPLE_BITS-1:0]  min_reg;
    logic [SAMPLE_BITS-1:0]  max_reg;
    logic [SAMPLE_BITS-1:0]  wet_reg;
    logic [SAMPLE_BITS-1:0]  humid_reg;
    logic [SAMPLE_BITS-1:0]  step_reg;

    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [POLL_BITS-1:0]    ticks_reg,   ticks_next;
    logic [SAMPLE_BITS-1:0]  prev_reg,    prev_next;
    logic [SAMPLE_BITS-1:0]  held_reg,    held_next;
    logic [ERRATIC_BITS-1:0] erratic_reg, erratic_next;
    msq_class_t              class_reg,   class_next;
    logic                    sampled_reg, sampled_next;
    logic                    zero_reg,    zero_next;

    msq_class_t              out_class_reg;
    logic [SAMPLE_BITS-1:0]  out_value_reg;
    logic [PERCENT_BITS-1:0] out_percent_reg;
    logic                    out_sampled_reg;

    logic [POLL_BITS:0]      elapsed;
    logic                    take;
    logic [SAMPLE_BITS-1:0]  diff;
    logic                    plausible;
    logic [ERRATIC_BITS-1:0] erratic_dec;
    logic [ERRATIC_BITS-1:0] erratic_inc;
    msq_class_t              sample_class;

    logic [SAMPLE_BITS-1:0]  num;
    logic [SAMPLE_BITS-1:0]  range_val;
    logic [NUM_BITS-1:0]     num_scaled;
    logic [DVD_BITS-1:0]     dividend;
    logic [DVD_BITS-1:0]     quotient;
    logic                    div_done;
    logic [PERCENT_BITS-1:0] percent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_reg  <= RST_POLL_PERIOD;
            min_reg   <= SAMPLE_BITS'(RST_MIN_VALUE);
            max_reg   <= SAMPLE_BITS'(RST_MAX_VALUE);
            wet_reg   <= SAMPLE_BITS'(RST_WET_THRESHOLD);
            humid_reg <= SAMPLE_BITS'(RST_HUMID_THRESHOLD);
            step_reg  <= SAMPLE_BITS'(RST_MAX_STEP);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_POLL_PERIOD:     poll_reg  <= cfg_wdata[POLL_BITS-1:0];
                REG_MIN_VALUE:       min_reg   <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_MAX_VALUE:       max_reg   <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_WET_THRESHOLD:   wet_reg   <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_HUMID_THRESHOLD: humid_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_MAX_STEP:        step_reg  <= cfg_wdata[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        elapsed     = {1'b0, ticks_reg} + (POLL_BITS + 1)'(1);
        take        = elapsed > {1'b0, poll_reg};
        diff        = (sample_reg >= prev_reg) ? (sample_reg - prev_reg)
                                               : (prev_reg - sample_reg);
        plausible   = (diff < step_reg) && (sample_reg > min_reg) && (sample_reg < max_reg);
        erratic_dec = (erratic_reg != '0) ? (erratic_reg - ERRATIC_BITS'(1)) : '0;
        erratic_inc = erratic_reg + ERRATIC_BITS'(1);

        if (sample_reg < wet_reg) begin
            sample_class = CLASS_WET;
        end else if (sample_reg < humid_reg) begin
            sample_class = CLASS_HUMID;
        end else begin
            sample_class = CLASS_DRY;
        end

        ticks_next   = ticks_reg;
        prev_next    = prev_reg;
        held_next    = held_reg;
        erratic_next = erratic_reg;
        class_next   = class_reg;
        sampled_next = sampled_reg;

        if (cmd.update) begin
            if (take) begin
                ticks_next   = '0;
                prev_next    = sample_reg;
                sampled_next = 1'b1;
                if (plausible) begin
                    erratic_next = erratic_dec;
                    if (erratic_dec == '0) begin
                        class_next = sample_class;
                        held_next  = sample_reg;
                    end
                end else if (erratic_inc > ERRATIC_LIMIT) begin
                    class_next   = CLASS_ERROR;
                    erratic_next = ERRATIC_LIMIT;
                end else begin
                    erratic_next = erratic_inc;
                end
            end else begin
                ticks_next   = elapsed[POLL_BITS-1:0];
                sampled_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg   <= '0;
            prev_reg    <= '0;
            held_reg    <= '0;
            erratic_reg <= '0;
            class_reg   <= CLASS_ERROR;
            sampled_reg <= 1'b0;
        end else begin
            ticks_reg   <= ticks_next;
            prev_reg    <= prev_next;
            held_reg    <= held_next;
            erratic_reg <= erratic_next;
            class_reg   <= class_next;
            sampled_reg <= sampled_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_sample;
        end
    end

    // Percent is (max - held) * 100 * 256 / (max - min).
    always_comb begin
        num        = (held_reg < max_reg) ? (max_reg - held_reg) : '0;
        range_val  = max_reg - min_reg;
        num_scaled = NUM_BITS'(num) * NUM_BITS'(PERCENT_SCALE);
        dividend   = {num_scaled, {PERCENT_FRAC_BITS{1'b0}}};
        zero_next  = (class_reg == CLASS_ERROR) || (max_reg <= min_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            zero_reg <= zero_next;
        end
    end

    msq_div #(
        .DIVIDEND_BITS (DVD_BITS),
        .DIVISOR_BITS  (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (range_val),
        .done     (div_done),
        .quotient (quotient)
    );

    assign status.div_done = div_done;

    always_comb begin
        if (zero_reg) begin
            percent = '0;
        end else if (quotient > DVD_BITS'(PERCENT_FULL)) begin
            percent = PERCENT_FULL;
        end else begin
            percent = quotient[PERCENT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_class_reg   <= class_reg;
            out_value_reg   <= held_reg;
            out_percent_reg <= percent;
            out_sampled_reg <= sampled_reg;
        end
    end

    assign m_tdata = OUT_BITS'({out_percent_reg, out_value_reg, out_class_reg});
    assign m_tuser = out_sampled_reg;

    `MSQ_ASSERT_ALWAYS(a_erratic_limit, aclk, aresetn, erratic_reg <= ERRATIC_LIMIT)
    `MSQ_ASSERT_NEXT(a_error_no_percent, aclk, aresetn, cmd.load_out && (class_reg == CLASS_ERROR), out_percent_reg == '0)
    `MSQ_ASSERT_NEXT(a_ticks_advance, aclk, aresetn, cmd.update && !take, ticks_reg != '0)

endmodule

`default_nettype wire

### hw/rtl/msq_ctrl.sv
`default_nettype none
`include "moisture_sample_qualifier_core_defines.svh"

module msq_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output msq_pkg::msq_cmd_t         cmd,
    input  wire msq_pkg::msq_status_t status
);

    import msq_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_UPDATE   = 5'b00010,
        ST_DIV_LOAD = 5'b00100,
        ST_DIV_RUN  = 5'b01000,
        ST_DONE     = 5'b10000
    } msq_state_t;

    msq_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    always_comb begin
        out_free      = !out_valid_reg || m_tready;
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (status.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    `MSQ_ASSERT_IMPLY(a_load_when_free, aclk, aresetn, cmd.load_out, !out_valid_reg || m_tready)
    `MSQ_ASSERT_NEXT(a_accept_then_update, aclk, aresetn, s_tvalid && s_tready, cmd.update)
    `MSQ_ASSERT_IMPLY(a_done_in_run, aclk, aresetn, status.div_done, state_reg == ST_DIV_RUN)

endmodule

`default_nettype wire

### hw/rtl/moisture_sample_qualifier_core.sv
`default_nettype none
// Channel   Dir  Data                                               User
// s_        in   s_tdata: sample                                    none
// m_        out  m_tdata: moisture_class, valid_value, percent     sampled
// cfg_      in   cfg_addr selects register, cfg_wdata is the value  none
//
// The next request can be accepted only once the current one has passed the
// restoring divider, which forms one quotient bit of the percent per cycle.
// Reset is synchronous and active low and leaves the class at error.
// One finished result waits in the output register while the next request is
// taken; if it is still not taken when that one finishes, the block holds.

module moisture_sample_qualifier_core #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                                            aclk,
    input  wire logic                                            aresetn,
    input  wire logic                                            s_tvalid,
    output logic                                                 s_tready,
    // sample
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]        s_tdata,
    output logic                                                 m_tvalid,
    input  wire logic                                            m_tready,
    // moisture_class, valid_value, moisture_percent
    output logic [((SAMPLE_BITS + 2 + 15 + 7) / 8) * 8 - 1:0]    m_tdata,
    // sampled
    output logic                                                 m_tuser,
    input  wire logic                                            cfg_we,
    input  wire logic [msq_pkg::CFG_ADDR_BITS-1:0]               cfg_addr,
    input  wire logic [msq_pkg::CFG_DATA_BITS-1:0]               cfg_wdata
);

    import msq_pkg::*;

    localparam int OUT_BITS = ((SAMPLE_BITS + CLASS_BITS + PERCENT_BITS + 7) / 8) * 8;

    msq_cmd_t    cmd;
    msq_status_t status;

    msq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    msq_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .OUT_BITS    (OUT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
